@@ rtl/core/ssp_pkg.sv @@
// Shared types, constants and helper functions for the scale-step pitch bend mapper.
package ssp_pkg;

    localparam int NoteW           = 7;
    localparam int StepW           = 7;
    localparam int BendW           = 14;
    localparam int IvW             = 7;
    localparam int SizeW           = 4;
    localparam int RangeW          = 7;
    localparam int NumIv           = 12;
    localparam int MaxScaleDegrees = 12;

    localparam logic [6:0]  RootReset   = 7'd60;
    localparam logic [3:0]  SizeReset   = 4'd7;
    localparam logic [41:0] IvLowReset  = 42'd311127245056;
    localparam logic [41:0] IvHighReset = 42'd11;
    localparam logic [6:0]  RangeReset  = 7'd2;

    localparam logic [13:0] BendCenter = 14'd8192;
    localparam logic [13:0] BendMax    = 14'd16383;
    localparam logic [6:0]  NoteMax    = 7'd127;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_ROOT    = 3'd0,
        REG_SIZE    = 3'd1,
        REG_IV_LOW  = 3'd2,
        REG_IV_HIGH = 3'd3,
        REG_RANGE   = 3'd4
    } cfg_idx_t;

    // All twelve intervals, entry 0 in the lowest bits
    typedef logic [NumIv*IvW-1:0] ivals_t;

    // Result of the degree search pipeline
    typedef struct packed {
        logic              valid;
        logic [6:0]        note;
        logic signed [6:0] step;
        logic signed [7:0] offset;
        logic [3:0]        best;
    } ssp_srch_t;

    // Pick one interval out of the packed set
    function automatic logic [6:0] ival_at(ivals_t all, logic [3:0] i);
        return all[i*IvW +: IvW];
    endfunction

    // Divide a 9-bit value by 12 with a reciprocal multiply (exact below 512)
    function automatic logic [5:0] div12(logic [8:0] v);
        logic [18:0] p;
        p = 19'(v) * 19'd683;
        return p[18:13];
    endfunction

    // Remainder of a 9-bit value by 12
    function automatic logic [3:0] mod12(logic [8:0] v);
        logic [8:0] r;
        r = v - 9'(div12(v)) * 9'd12;
        return r[3:0];
    endfunction

endpackage

@@ rtl/core/ssp_divider.sv @@
// Pipelined restoring divider, one quotient bit per stage, with side payload.
module ssp_divider #(
    parameter int NW = 22,
    parameter int DW = 8,
    parameter int QW = 14,
    parameter int PW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_den,
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    output logic [QW-1:0] out_quo,
    output logic [DW-1:0] out_rem,
    output logic [PW-1:0] out_pay
);

    logic          vld_reg [QW];
    logic [NW-1:0] rem_reg [QW];
    logic [QW-1:0] quo_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [PW-1:0] pay_reg [QW];

    genvar j;
    for (j = 0; j < QW; j++) begin : g_stage
        logic          v_in;
        logic [NW-1:0] r_in;
        logic [QW-1:0] q_in;
        logic [DW-1:0] d_in;
        logic [PW-1:0] p_in;
        logic [NW-1:0] trial;
        logic [NW-1:0] r_next;
        logic [QW-1:0] q_next;

        if (j == 0) begin : g_first
            assign v_in = in_valid;
            assign r_in = in_num;
            assign q_in = '0;
            assign d_in = in_den;
            assign p_in = in_pay;
        end else begin : g_rest
            assign v_in = vld_reg[j-1];
            assign r_in = rem_reg[j-1];
            assign q_in = quo_reg[j-1];
            assign d_in = den_reg[j-1];
            assign p_in = pay_reg[j-1];
        end

        // Try to subtract the shifted divisor for this quotient bit
        assign trial = NW'(d_in) << (QW - 1 - j);

        always_comb begin
            r_next = r_in;
            q_next = q_in;
            if (r_in >= trial) begin
                r_next = r_in - trial;
                q_next[QW-1-j] = 1'b1;
            end
        end

        // Advance valid bit
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (en) begin
                vld_reg[j] <= v_in;
            end
        end

        // Advance data
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j] <= r_next;
                quo_reg[j] <= q_next;
                den_reg[j] <= d_in;
                pay_reg[j] <= p_in;
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign out_quo   = quo_reg[QW-1];
    assign out_rem   = rem_reg[QW-1][DW-1:0];
    assign out_pay   = pay_reg[QW-1];

endmodule

@@ rtl/core/ssp_search.sv @@
// Three-stage search for the scale degree nearest to the note's chromatic position.
module ssp_search #(
    parameter int MAX_DEG = ssp_pkg::MaxScaleDegrees
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [6:0]        in_note,
    input  logic signed [6:0] in_step,
    input  logic [6:0]        root,
    input  logic [3:0]        size_c,
    input  ssp_pkg::ivals_t   ivals,
    output ssp_pkg::ssp_srch_t srch
);
    import ssp_pkg::*;

    logic [3:0] ivc [NumIv];

    logic              a_valid_reg;
    logic [6:0]        a_note_reg;
    logic signed [6:0] a_step_reg;
    logic signed [7:0] a_offset_reg;
    logic [3:0]        a_chroma_reg;

    logic              b_valid_reg;
    logic [6:0]        b_note_reg;
    logic signed [6:0] b_step_reg;
    logic signed [7:0] b_offset_reg;
    logic [3:0]        b_chroma_reg;
    logic [3:0]        b_best_reg;
    logic [3:0]        b_dist_reg;

    ssp_srch_t c_reg;

    logic signed [7:0] offset_next;
    logic [8:0]        shifted;
    logic [3:0]        b_best_next, b_dist_next;
    logic [3:0]        c_best_next, c_dist_next;

    // Chromatic position of each interval
    always_comb begin
        for (int i = 0; i < NumIv; i++) begin
            ivc[i] = mod12({2'b00, ival_at(ivals, 4'(i))});
        end
    end

    // Stage A: offset from root and its chromatic position
    assign offset_next = $signed({1'b0, in_note}) - $signed({1'b0, root});
    assign shifted     = 9'({offset_next[7], offset_next} + 9'd132);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_note_reg   <= in_note;
            a_step_reg   <= in_step;
            a_offset_reg <= offset_next;
            a_chroma_reg <= mod12(shifted);
        end
    end

    // Stage B: scan entries 0..5, first entry wins ties
    always_comb begin
        logic [3:0] d;
        b_best_next = '0;
        b_dist_next = 4'd12;
        for (int i = 0; i < 6; i++) begin
            d = (a_chroma_reg >= ivc[i]) ? a_chroma_reg - ivc[i] : ivc[i] - a_chroma_reg;
            if (i < MAX_DEG && 4'(i) < size_c && d < b_dist_next) begin
                b_dist_next = d;
                b_best_next = 4'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_note_reg   <= a_note_reg;
            b_step_reg   <= a_step_reg;
            b_offset_reg <= a_offset_reg;
            b_chroma_reg <= a_chroma_reg;
            b_best_reg   <= b_best_next;
            b_dist_reg   <= b_dist_next;
        end
    end

    // Stage C: scan entries 6..11
    always_comb begin
        logic [3:0] d;
        c_best_next = b_best_reg;
        c_dist_next = b_dist_reg;
        for (int i = 6; i < NumIv; i++) begin
            d = (b_chroma_reg >= ivc[i]) ? b_chroma_reg - ivc[i] : ivc[i] - b_chroma_reg;
            if (i < MAX_DEG && 4'(i) < size_c && d < c_dist_next) begin
                c_dist_next = d;
                c_best_next = 4'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_reg.valid <= 1'b0;
        end else if (en) begin
            c_reg.valid <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_reg.note   <= b_note_reg;
            c_reg.step   <= b_step_reg;
            c_reg.offset <= b_offset_reg;
            c_reg.best   <= c_best_next;
        end
    end

    assign srch = c_reg;

endmodule

@@ rtl/core/scale_step_pitch_bend_mapper.sv @@
// Top level: maps a note and a scale-step offset to a target note and pitch bend.
// Throughput: one request per cycle; the whole pipeline holds while the result
// register is full and not taken. Pipeline stages from request to result: degree
// search 3, degree 1, step divider 7, note 1, bend prep 1, bend divider 14, output 1.
// Reset: synchronous, active low; empties the pipeline and loads register defaults.
module scale_step_pitch_bend_mapper #(
    parameter int MAX_SCALE_DEGREES = ssp_pkg::MaxScaleDegrees
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [6:0] note, [13:7] step_offset, [15:14] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [13:0] bend_value, [20:14] target_note, [23:21] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [41:0] cfg_data
);
    import ssp_pkg::*;

    logic [6:0]  root_reg;
    logic [3:0]  size_reg;
    logic [41:0] iv_low_reg;
    logic [41:0] iv_high_reg;
    logic [6:0]  range_reg;

    logic       en;
    logic [3:0] size_c;
    logic [6:0] rng;
    ivals_t     ivals;
    ssp_srch_t  srch;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg    <= RootReset;
            size_reg    <= SizeReset;
            iv_low_reg  <= IvLowReset;
            iv_high_reg <= IvHighReset;
            range_reg   <= RangeReset;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_ROOT:    root_reg    <= cfg_data[6:0];
                REG_SIZE:    size_reg    <= cfg_data[3:0];
                REG_IV_LOW:  iv_low_reg  <= cfg_data;
                REG_IV_HIGH: iv_high_reg <= cfg_data;
                REG_RANGE:   range_reg   <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign size_c = (size_reg > 4'(MAX_SCALE_DEGREES)) ? 4'(MAX_SCALE_DEGREES) : size_reg;
    assign rng    = (range_reg == '0) ? 7'd1 : range_reg;
    assign ivals  = {iv_high_reg, iv_low_reg};

    // Hold the whole pipeline while the result waits
    logic m_valid_reg;
    logic [13:0] m_bend_reg;
    logic [6:0]  m_target_reg;

    assign en            = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    ssp_search #(.MAX_DEG(MAX_SCALE_DEGREES)) u_search (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_axis_tvalid),
        .in_note  (s_axis_tdata[6:0]),
        .in_step  ($signed(s_axis_tdata[13:7])),
        .root     (root_reg),
        .size_c   (size_c),
        .ivals    (ivals),
        .srch     (srch)
    );

    // Stage D: octave of the found degree and in-octave step sum
    logic              d_valid_reg;
    logic [6:0]        d_note_reg;
    logic signed [5:0] d_k_reg;
    logic signed [7:0] d_x_reg;
    logic              d_empty_reg;

    logic [9:0]        w10;
    logic signed [7:0] x_next;

    assign w10    = {{2{srch.offset[7]}}, srch.offset} - {3'b000, ival_at(ivals, srch.best)}
                    + 10'd264;
    assign x_next = {4'b0000, srch.best} + {srch.step[6], srch.step};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (en) begin
            d_valid_reg <= srch.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_note_reg  <= srch.note;
            d_k_reg     <= $signed(div12(w10[8:0]) - 6'd22);
            d_x_reg     <= x_next;
            d_empty_reg <= (size_c == '0);
        end
    end

    // Divide the step sum magnitude by the scale size
    logic [7:0]  x_abs;
    logic        q1_valid;
    logic [6:0]  q1_quo;
    logic [3:0]  q1_rem;
    logic [14:0] q1_pay;

    assign x_abs = d_x_reg[7] ? 8'(-d_x_reg) : d_x_reg;

    ssp_divider #(.NW(11), .DW(4), .QW(7), .PW(15)) u_step_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d_valid_reg),
        .in_num    ({3'b000, x_abs}),
        .in_den    (d_empty_reg ? 4'd1 : size_c),
        .in_pay    ({d_note_reg, d_k_reg, d_x_reg[7], d_empty_reg}),
        .out_valid (q1_valid),
        .out_quo   (q1_quo),
        .out_rem   (q1_rem),
        .out_pay   (q1_pay)
    );

    // Stage E: floor quotient, degree index and clamped target note
    logic              e_valid_reg;
    logic [6:0]        e_note_reg;
    logic [6:0]        e_target_reg;
    logic              e_empty_reg;

    logic [6:0]         e_note_in;
    logic signed [5:0]  e_k_in;
    logic               e_neg_in, e_empty_in;
    logic signed [7:0]  fq;
    logic [3:0]         idx;
    logic signed [8:0]  qtot;
    logic signed [11:0] q12, res;
    logic [6:0]         target_next;

    assign {e_note_in, e_k_in, e_neg_in, e_empty_in} = q1_pay;

    always_comb begin
        if (e_neg_in && q1_rem != '0) begin
            fq  = -$signed({1'b0, q1_quo} + 8'd1);
            idx = size_c - q1_rem;
        end else begin
            fq  = e_neg_in ? -$signed({1'b0, q1_quo}) : $signed({1'b0, q1_quo});
            idx = q1_rem;
        end
        qtot = {{3{e_k_in[5]}}, e_k_in} + {fq[7], fq};
        q12  = {{3{qtot[8]}}, qtot};
        res  = {5'b00000, root_reg} + (q12 <<< 3) + (q12 <<< 2)
               + {5'b00000, ival_at(ivals, idx)};
        if (e_empty_in) begin
            target_next = e_note_in;
        end else if (res[11]) begin
            target_next = '0;
        end else if (res > 12'sd127) begin
            target_next = NoteMax;
        end else begin
            target_next = res[6:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (en) begin
            e_valid_reg <= q1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_note_reg   <= e_note_in;
            e_target_reg <= target_next;
            e_empty_reg  <= e_empty_in;
        end
    end

    // Stage F: semitone difference and bend dividend
    logic              f_valid_reg;
    logic [6:0]        f_target_reg;
    logic              f_neg_reg;
    logic              f_sat_reg;
    logic              f_empty_reg;
    logic [21:0]       f_num_reg;
    logic [7:0]        f_den_reg;

    logic signed [7:0] delta;
    logic [6:0]        mag;
    logic [21:0]       num22, lim22;

    assign delta = $signed({1'b0, e_target_reg}) - $signed({1'b0, e_note_reg});
    assign mag   = delta[7] ? 7'(-delta) : delta[6:0];
    assign num22 = {1'b0, mag, 14'b0} + 22'(rng);
    assign lim22 = {rng, 15'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (en) begin
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_target_reg <= e_target_reg;
            f_neg_reg    <= delta[7];
            f_sat_reg    <= (num22 >= lim22);
            f_empty_reg  <= e_empty_reg;
            f_num_reg    <= (num22 >= lim22) ? '0 : num22;
            f_den_reg    <= {rng, 1'b0};
        end
    end

    // Rounded bend magnitude: (2*mag*8192 + range) / (2*range)
    logic        q2_valid;
    logic [13:0] q2_quo;
    logic [7:0]  q2_rem;
    logic [9:0]  q2_pay;

    ssp_divider #(.NW(22), .DW(8), .QW(14), .PW(10)) u_bend_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid_reg),
        .in_num    (f_num_reg),
        .in_den    (f_den_reg),
        .in_pay    ({f_target_reg, f_neg_reg, f_sat_reg, f_empty_reg}),
        .out_valid (q2_valid),
        .out_quo   (q2_quo),
        .out_rem   (q2_rem),
        .out_pay   (q2_pay)
    );

    // Stage G: apply sign, clamp and load the result register
    logic [6:0]  g_target;
    logic        g_neg, g_sat, g_empty;
    logic [13:0] qc;
    logic [13:0] bend_next;

    assign {g_target, g_neg, g_sat, g_empty} = q2_pay;
    assign qc = g_sat ? BendMax : q2_quo;

    always_comb begin
        if (g_empty) begin
            bend_next = BendCenter;
        end else if (g_neg) begin
            bend_next = (qc >= BendCenter) ? '0 : BendCenter - qc;
        end else begin
            bend_next = (qc >= BendCenter - 14'd1) ? BendMax : BendCenter + qc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= q2_valid;
        end
    end

    // The divider remainder carries no information for the result
    always_ff @(posedge aclk) begin
        if (en) begin
            m_bend_reg   <= bend_next;
            m_target_reg <= g_target;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'b000, m_target_reg, m_bend_reg};

    logic unused_rem;
    assign unused_rem = ^q2_rem;

endmodule

@@ tb/scale_step_pitch_bend_mapper_tb.sv @@
// Self-checking testbench for the scale-step pitch bend mapper.
`timescale 1ns / 1ps

module scale_step_pitch_bend_mapper_tb;
    import ssp_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [6:0] note, [13:7] step_offset
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // [13:0] bend_value, [20:14] target_note
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [41:0] cfg_data;

    int  error_count;
    bit  quiet_phase;

    scale_step_pitch_bend_mapper i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    typedef struct packed {
        logic [6:0]  note;
        logic [13:0] bend;
    } bend_result_t;

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // Bend mapper predictor with its own register copy and queue of pending results
    class bend_scoreboard;
        logic [6:0]  root;
        logic [3:0]  size;
        logic [41:0] iv_low;
        logic [41:0] iv_high;
        logic [6:0]  range;
        bend_result_t pending[$];

        function new();
            root = RootReset; size = SizeReset;
            iv_low = IvLowReset; iv_high = IvHighReset; range = RangeReset;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [41:0] val);
            case (idx)
                REG_ROOT:    root = val[6:0];
                REG_SIZE:    size = val[3:0];
                REG_IV_LOW:  iv_low = val;
                REG_IV_HIGH: iv_high = val;
                REG_RANGE:   range = val[6:0];
                default: ;
            endcase
        endfunction

        function int ival(int i);
            if (i < 6) return int'(iv_low[7*i +: 7]);
            return int'(iv_high[7*(i-6) +: 7]);
        endfunction

        function int fdiv(int a, int b);
            int q;
            q = a / b;
            if ((a % b) != 0 && a < 0) q--;
            return q;
        endfunction

        // Predict the result of one accepted request
        function void note_request(logic [6:0] note, logic signed [6:0] step);
            int n, sz, rng, off, chroma, best, bdist, d, deg, tgt, q, idx, res, dl, mag, bend;
            bend_result_t r;
            n = int'(note);
            sz = (size > 12) ? 12 : int'(size);
            rng = (range == 0) ? 1 : int'(range);
            if (sz == 0) begin
                r.note = note; r.bend = BendCenter;
                pending.push_back(r);
                return;
            end
            off = n - int'(root);
            chroma = off - 12 * fdiv(off, 12);
            best = 0; bdist = 12;
            for (int i = 0; i < sz; i++) begin
                d = chroma - ival(i) % 12;
                if (d < 0) d = -d;
                if (d < bdist) begin
                    bdist = d; best = i;
                end
            end
            deg = best + sz * fdiv(off - ival(best), 12);
            tgt = deg + int'(step);
            q = fdiv(tgt, sz);
            idx = tgt - q * sz;
            res = int'(root) + q * 12 + ival(idx);
            if (res < 0) res = 0;
            if (res > 127) res = 127;
            dl = res - n;
            mag = dl < 0 ? -dl : dl;
            q = (2 * mag * 8192 + rng) / (2 * rng);
            bend = dl < 0 ? 8192 - q : 8192 + q;
            if (bend < 0) bend = 0;
            if (bend > 16383) bend = 16383;
            r.note = res[6:0]; r.bend = bend[13:0];
            pending.push_back(r);
        endfunction

        // Compare one accepted result with the oldest prediction
        task check_result(logic [23:0] data);
            bend_result_t w;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", int'(data), -1);
                return;
            end
            w = pending.pop_front();
            if (data[13:0] != w.bend) report_mismatch("bend_value", data[13:0], w.bend);
            if (data[20:14] != w.note) report_mismatch("target_note", data[20:14], w.note);
            if (data[23:21] != 0) report_mismatch("pad bits", data[23:21], 0);
        endtask
    endclass

    bend_scoreboard sb;

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        #50ms;
        $display("** scale_step_pitch_bend_mapper: FAILED **");
        $finish;
    end

    // Result side: random stall bursts, check each accepted result
    initial begin
        int stall;
        m_axis_tready = 0;
        stall = 0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
            if (stall > 0) begin
                stall--;
                m_axis_tready <= 0;
            end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(0, 3);
                m_axis_tready <= 0;
            end else begin
                m_axis_tready <= 1;
            end
        end
    end

    // Send one request, with an optional random gap first
    task automatic send_request(logic [6:0] note, logic [6:0] step);
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {2'b00, step, note};
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_request(note, step);
    endtask

    task automatic idle_input();
        s_axis_tvalid <= 0;
        @(posedge aclk);
    endtask

    // Wait until every prediction is matched, then let the pipeline drain
    task automatic drain();
        idle_input();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [41:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    function automatic logic [41:0] pack6(int a, int b, int c, int d, int e, int f);
        return {7'(f), 7'(e), 7'(d), 7'(c), 7'(b), 7'(a)};
    endfunction

    function automatic logic [6:0] rand_step();
        if ($urandom_range(0, 3) == 0) return 7'($urandom);
        return 7'($urandom_range(0, 16) - 8);
    endfunction

    task automatic random_config();
        write_reg(REG_ROOT, $urandom_range(0, 3) == 0 ? 42'($urandom_range(0, 127))
                                                      : 42'($urandom_range(40, 80)));
        write_reg(REG_SIZE, 42'($urandom_range(0, 15)));
        if ($urandom_range(0, 2) == 0)
            write_reg(REG_IV_LOW, {10'($urandom), $urandom});
        else
            write_reg(REG_IV_LOW, pack6(0, $urandom_range(1, 3), $urandom_range(3, 5),
                                        $urandom_range(5, 6), $urandom_range(7, 8),
                                        $urandom_range(8, 10)));
        if ($urandom_range(0, 2) == 0)
            write_reg(REG_IV_HIGH, {10'($urandom), $urandom});
        else
            write_reg(REG_IV_HIGH, pack6($urandom_range(9, 11), 11, 12, 14, 16, 17));
        write_reg(REG_RANGE, 42'($urandom_range(0, 3) == 0 ? $urandom_range(0, 127)
                                                           : $urandom_range(0, 24)));
    endtask

    initial begin
        sb = new();
        error_count = 0;
        quiet_phase = 0;
        aresetn = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        cfg_valid = 0;
        cfg_index = REG_ROOT;
        cfg_data = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: reset scale, field extremes
        send_request(7'd0, 7'd0);
        send_request(7'd127, 7'd0);
        send_request(7'd60, 7'h3F);
        send_request(7'd60, 7'h40);
        send_request(7'd0, 7'h40);
        send_request(7'd127, 7'h3F);
        send_request(7'd61, 7'd1);
        send_request(7'd66, 7'h7F);
        // Sender holds off until everything is back
        drain();

        // Empty scale, zero range
        write_reg(REG_SIZE, 42'd0);
        write_reg(REG_RANGE, 42'd0);
        send_request(7'd45, 7'd5);
        send_request(7'd127, 7'h40);
        drain();
        // Oversized scale, intervals of 12 and above, zero range, extreme root
        write_reg(REG_SIZE, 42'd15);
        write_reg(REG_ROOT, 42'd127);
        write_reg(REG_IV_LOW, pack6(0, 13, 26, 127, 4, 5));
        write_reg(REG_IV_HIGH, {42{1'b1}});
        send_request(7'd0, 7'h40);
        send_request(7'd127, 7'd3);
        send_request(7'd64, 7'h3F);
        drain();
        write_reg(REG_ROOT, 42'd0);
        write_reg(REG_RANGE, 42'd96);
        write_reg(REG_IV_LOW, 42'd0);
        write_reg(REG_IV_HIGH, 42'd0);
        write_reg(REG_SIZE, 42'd1);
        send_request(7'd127, 7'h40);
        send_request(7'd5, 7'h3F);
        drain();
        write_reg(REG_RANGE, 42'd1);
        send_request(7'd0, 7'h3F);
        send_request(7'd127, 7'h40);
        drain();
        write_reg(REG_RANGE, 42'd127);
        send_request(7'd30, 7'd7);
        drain();

        // Random phases
        for (int ph = 0; ph < 30; ph++) begin
            random_config();
            if (ph == 28) quiet_phase = 1;
            for (int k = 0; k < 60; k++)
                send_request(7'($urandom), rand_step());
            drain();
        end

        if (error_count == 0) begin
            $display("** scale_step_pitch_bend_mapper: PASSED **");
        end else begin
            $display("** scale_step_pitch_bend_mapper: FAILED **");
        end
        $finish;
    end
endmodule
